// ===== rtl/kdw_pkg.sv =====
// ----------------------------------------------------------------------------
// kdw_pkg
// Shared widths, defaults and event codes for the key debounce and wheel
// decode block.
// ----------------------------------------------------------------------------
package kdw_pkg;

    // Fixed field widths
    localparam int LEVEL_W   = 9;   // key_levels
    localparam int TICKS_W   = 16;  // press_ticks
    localparam int KIND_W    = 2;   // event_kind
    localparam int KEY_IDX_W = 4;   // key_index

    // Parameter defaults
    localparam int DEF_NUM_KEYS    = 9;
    localparam int DEF_COUNT_WIDTH = 16;

    // Reset value of the press threshold register
    localparam logic [TICKS_W-1:0] PRESS_TICKS_RST = 16'd20;

    // Event codes
    typedef enum logic [KIND_W-1:0] {
        EV_KEY_DOWN   = 2'd0,
        EV_KEY_UP     = 2'd1,
        EV_WHEEL_DOWN = 2'd2,
        EV_WHEEL_UP   = 2'd3
    } t_event_kind;

endpackage

// ===== rtl/kdw_ifs.sv =====
// ----------------------------------------------------------------------------
// kdw_ifs
// Valid/ready channel interfaces: tick input, event output, config write.
// ----------------------------------------------------------------------------

// Tick input channel
interface kdw_in_if;
    logic                        valid;
    logic                        ready;
    logic [kdw_pkg::LEVEL_W-1:0] key_levels;
    logic                        phase_a;
    logic                        phase_b;

    modport source (output valid, output key_levels, output phase_a,
                    output phase_b, input ready);
    modport sink   (input valid, input key_levels, input phase_a,
                    input phase_b, output ready);
endinterface

// Event output channel
interface kdw_out_if;
    logic                          valid;
    logic                          ready;
    logic [kdw_pkg::KIND_W-1:0]    event_kind;
    logic [kdw_pkg::KEY_IDX_W-1:0] key_index;
    logic                          last_event;

    modport source (output valid, output event_kind, output key_index,
                    output last_event, input ready);
    modport sink   (input valid, input event_kind, input key_index,
                    input last_event, output ready);
endinterface

// Config write channel
interface kdw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [kdw_pkg::TICKS_W-1:0] press_ticks;

    modport source (output valid, output press_ticks, input ready);
    modport sink   (input valid, input press_ticks, output ready);
endinterface

// ===== rtl/key_debounce_and_wheel_decode_top.sv =====
// ----------------------------------------------------------------------------
// key_debounce_and_wheel_decode_top
// Per-key debouncer with long-press threshold plus quadrature wheel decoder.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one transfer per timer tick (key levels, active low, and the two
//            wheel phase pins). Ready is high only between ticks.
//   o_out  : zero to NUM_KEYS+1 event transfers per tick, keys in index order,
//            then the wheel; last_event marks the final event of the tick.
//            A tick with no events produces no transfer.
//   i_cfg  : press_ticks write, always ready; write only while idle.
// Throughput: a sequencer walks the key state memory one entry per cycle
//   while no stall holds it (read into a register, then modified and written
//   back in stage 2), so the tick rate is set by the single memory read port
//   and the key count; a new tick is taken only once the last one is done.
// Pending: an event waits in a pending slot until the next event of the tick
//   or the flush state, so its last flag is known; the final event is moved
//   into the output register in the flush state.
// Stall: when a new event needs the pending slot while the output register
//   is full and not taken, the sequencer freezes; no event is dropped.
// Reset: the key state entries read as idle with a zero counter until first
//   written (per-entry valid bits), wheel history clears to zero and
//   press_ticks returns to 20.
// ----------------------------------------------------------------------------
module key_debounce_and_wheel_decode_top #(
    parameter int NUM_KEYS    = kdw_pkg::DEF_NUM_KEYS,
    parameter int COUNT_WIDTH = kdw_pkg::DEF_COUNT_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kdw_in_if.sink     i_in,
    kdw_out_if.source  o_out,
    kdw_cfg_if.sink    i_cfg
);

    localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int POS_W  = $clog2(NUM_KEYS + 2);   // holds NUM_KEYS+1
    localparam int ENT_W  = 2 + COUNT_WIDTH;
    localparam int CMP_W  = (COUNT_WIDTH > kdw_pkg::TICKS_W) ? COUNT_WIDTH
                                                             : kdw_pkg::TICKS_W;
    localparam logic [POS_W-1:0] POS_WHEEL = POS_W'(NUM_KEYS);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_HELD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_key_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_seq_state;

    // Key state memory: {phase, counter}
    logic [ENT_W-1:0]    mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_ent_vld;
    logic [ENT_W-1:0]    r_rd_data;
    logic                r_rd_vld;

    t_seq_state              r_state;
    logic [POS_W-1:0]        r_s1_pos;
    logic                    r_s2_valid;
    logic [POS_W-1:0]        r_s2_pos;
    logic [NUM_KEYS-1:0]     r_pressed;
    logic                    r_wh_valid;
    kdw_pkg::t_event_kind    r_wh_kind;
    logic                    r_prev_a;
    logic                    r_prev_b;
    logic [kdw_pkg::TICKS_W-1:0] r_press_ticks;

    // Pending event slot and output register
    logic                            r_pend_valid;
    kdw_pkg::t_event_kind            r_pend_kind;
    logic [kdw_pkg::KEY_IDX_W-1:0]   r_pend_idx;
    logic                            r_out_valid;
    kdw_pkg::t_event_kind            r_out_kind;
    logic [kdw_pkg::KEY_IDX_W-1:0]   r_out_idx;
    logic                            r_out_last;

    logic                 in_xfer;
    logic                 out_free;
    logic                 out_load;
    logic                 s1_issue;
    logic                 rd_en;
    logic [ADDR_W-1:0]    s1_addr;
    logic [ADDR_W-1:0]    s2_addr;
    logic                 s2_is_key;
    logic                 stall;
    logic                 advance;
    logic                 wr_en;

    logic [NUM_KEYS+kdw_pkg::LEVEL_W-1:0] lv_pad;
    logic [NUM_KEYS-1:0]  pressed_in;

    t_key_phase           cur_ph;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    t_key_phase           n_ph;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic                 s2_ev_valid;
    kdw_pkg::t_event_kind s2_ev_kind;
    logic [kdw_pkg::KEY_IDX_W-1:0] s2_ev_idx;
    logic [31:0]          s2_pos32;
    logic                 key_pressed;

    logic                 n_wh_valid;
    kdw_pkg::t_event_kind n_wh_kind;

    // Handshakes
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_out_kind;
    assign o_out.key_index  = r_out_idx;
    assign o_out.last_event = r_out_last;

    // Keys beyond the level field read as released
    assign lv_pad     = {{NUM_KEYS{1'b1}}, i_in.key_levels};
    assign pressed_in = ~lv_pad[NUM_KEYS-1:0];

    // Wheel decode at tick transfer
    always_comb begin
        n_wh_valid = 1'b0;
        n_wh_kind  = kdw_pkg::EV_WHEEL_DOWN;
        if (i_in.phase_a != i_in.phase_b) begin
            if (r_prev_a && r_prev_b) begin
                n_wh_valid = 1'b1;
                n_wh_kind  = i_in.phase_a ? kdw_pkg::EV_WHEEL_UP
                                          : kdw_pkg::EV_WHEEL_DOWN;
            end else if (!r_prev_a && !r_prev_b) begin
                n_wh_valid = 1'b1;
                n_wh_kind  = i_in.phase_a ? kdw_pkg::EV_WHEEL_DOWN
                                          : kdw_pkg::EV_WHEEL_UP;
            end
        end
    end

    // Stage 1: issue a read for the next position
    assign s1_issue = (r_state == ST_RUN) && (r_s1_pos <= POS_WHEEL);
    assign s1_addr  = r_s1_pos[ADDR_W-1:0];
    assign rd_en    = s1_issue && (r_s1_pos < POS_WHEEL) && !stall;

    // Stage 2: modify the entry that stage 1 read
    assign s2_addr   = r_s2_pos[ADDR_W-1:0];
    assign s2_is_key = (r_s2_pos < POS_WHEEL);
    assign s2_pos32  = 32'(r_s2_pos);
    assign key_pressed = r_pressed[s2_addr];

    always_comb begin
        if (r_rd_vld) begin
            cur_ph  = t_key_phase'(r_rd_data[ENT_W-1 -: 2]);
            cur_cnt = r_rd_data[COUNT_WIDTH-1:0];
        end else begin
            cur_ph  = PH_IDLE;
            cur_cnt = '0;
        end
        cnt_inc = (cur_cnt == {COUNT_WIDTH{1'b1}}) ? cur_cnt
                                                   : cur_cnt + COUNT_WIDTH'(1);
        n_ph        = cur_ph;
        n_cnt       = cnt_inc;
        s2_ev_valid = 1'b0;
        s2_ev_kind  = kdw_pkg::EV_KEY_DOWN;
        s2_ev_idx   = s2_pos32[kdw_pkg::KEY_IDX_W-1:0];
        if (s2_is_key) begin
            unique case (cur_ph)
                PH_IDLE: begin
                    if (key_pressed) begin
                        n_cnt = '0;
                        n_ph  = PH_PRESS;
                    end
                end
                PH_PRESS: begin
                    if (!key_pressed) begin
                        n_ph = PH_IDLE;
                    end else if (CMP_W'(cnt_inc) > CMP_W'(r_press_ticks)) begin
                        s2_ev_valid = 1'b1;
                        s2_ev_kind  = kdw_pkg::EV_KEY_DOWN;
                        n_cnt       = '0;
                        n_ph        = PH_HELD;
                    end
                end
                PH_HELD: begin
                    if (!key_pressed) begin
                        n_ph = PH_RELEASE;
                    end
                end
                PH_RELEASE: begin
                    s2_ev_valid = 1'b1;
                    s2_ev_kind  = kdw_pkg::EV_KEY_UP;
                    n_ph        = PH_IDLE;
                end
            endcase
        end else begin
            // wheel step
            s2_ev_valid = r_wh_valid;
            s2_ev_kind  = r_wh_kind;
            s2_ev_idx   = '0;
        end
    end

    // A new event needs the pending slot emptied into a free output register
    assign stall   = (r_state == ST_RUN) && r_s2_valid && s2_ev_valid
                     && r_pend_valid && !out_free;
    assign advance = (r_state == ST_RUN) && !stall;
    assign wr_en   = advance && r_s2_valid && s2_is_key;

    // Output register loads from the pending slot
    assign out_load = (advance && r_s2_valid && s2_ev_valid && r_pend_valid)
                      || ((r_state == ST_FLUSH) && r_pend_valid && out_free);

    // Key state memory, read and write ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[s2_addr] <= {logic'(n_ph[1]), logic'(n_ph[0]), n_cnt};
        end
        if (rd_en) begin
            r_rd_data <= mem[s1_addr];
        end
    end

    // Sequencer, wheel history, config and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ent_vld     <= '0;
            r_rd_vld      <= 1'b0;
            r_s1_pos      <= '0;
            r_s2_valid    <= 1'b0;
            r_s2_pos      <= '0;
            r_wh_valid    <= 1'b0;
            r_prev_a      <= 1'b0;
            r_prev_b      <= 1'b0;
            r_press_ticks <= kdw_pkg::PRESS_TICKS_RST;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_press_ticks <= i_cfg.press_ticks;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (rd_en) begin
                r_rd_vld <= r_ent_vld[s1_addr];
            end
            if (wr_en) begin
                r_ent_vld[s2_addr] <= 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_pressed  <= pressed_in;
                        r_wh_valid <= n_wh_valid;
                        r_wh_kind  <= n_wh_kind;
                        r_prev_a   <= i_in.phase_a;
                        r_prev_b   <= i_in.phase_b;
                        r_s1_pos   <= '0;
                        r_s2_valid <= 1'b0;
                        r_state    <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (advance) begin
                        // stage 2 retires, event goes through the pending slot
                        if (r_s2_valid && s2_ev_valid) begin
                            if (r_pend_valid) begin
                                r_out_kind  <= r_pend_kind;
                                r_out_idx   <= r_pend_idx;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_kind  <= s2_ev_kind;
                            r_pend_idx   <= s2_ev_idx;
                        end
                        // stage 1 moves into stage 2
                        r_s2_valid <= s1_issue;
                        r_s2_pos   <= r_s1_pos;
                        if (s1_issue) begin
                            r_s1_pos <= r_s1_pos + POS_W'(1);
                        end
                        if (r_s2_valid && !s2_is_key) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out_kind   <= r_pend_kind;
                        r_out_idx    <= r_pend_idx;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/kdw_checker.sv =====
// ----------------------------------------------------------------------------
// kdw_checker
// Port-level assertions for the key debounce and wheel decode block.
// ----------------------------------------------------------------------------
module kdw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [kdw_pkg::KIND_W-1:0]    i_out_kind,
    input logic [kdw_pkg::KEY_IDX_W-1:0] i_out_idx,
    input logic                          i_out_last
);

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A tick transfer closes the input until the tick is done
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a tick transfer");

    // Wheel events carry key index zero
    a_wheel_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == kdw_pkg::EV_WHEEL_DOWN
                         || i_out_kind == kdw_pkg::EV_WHEEL_UP))
        |-> (i_out_idx == '0))
        else $error("wheel event with nonzero key index");

    // Stalled event holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_kind) && $stable(i_out_idx)
         && $stable(i_out_last)))
        else $error("stalled event changed");

endmodule

bind key_debounce_and_wheel_decode_top kdw_checker u_kdw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.event_kind),
    .i_out_idx   (o_out.key_index),
    .i_out_last  (o_out.last_event)
);
